### hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds the request and result structs, the opcode and status codes.
// Used by every module of the allocator.
`default_nettype none

package ffha_pkg;

  // Operation codes carried in the request.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MEMORY = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_BAD_PTR   = 3'd3,
    ST_ZERO_NULL = 3'd4
  } status_t;

  // Base address of the heap in the address map.
  localparam logic [31:0] HEAP_BASE = 32'h0100_0000;

  // Page budget register.
  localparam int BUDGET_W = 14;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 14'd12288;

  // Configuration bus data width and register address.
  localparam int APB_DW = 32;
  localparam logic [1:0] ADDR_BUDGET = 2'd0;

  typedef struct packed {
    logic        func;
    logic [31:0] req_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] alloc_address;
    logic [25:0] held_bytes;
    logic [25:0] spare_bytes;
    logic [8:0]  block_count;
    logic [13:0] heap_pages;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/ffha_cell.sv
// One cell of the block table chain: holds one block entry.
// On each shift it takes the entry of its right-hand neighbor.
// Depends on ffha_pkg.
`default_nettype none

module ffha_cell
  import ffha_pkg::*;
#(
  parameter int W         = 26,
  parameter int INIT_SIZE = 4080
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         shift,
  input  wire logic [W-1:0] in_off,
  input  wire logic [W-1:0] in_size,
  input  wire logic         in_free,
  output logic      [W-1:0] off,
  output logic      [W-1:0] size,
  output logic              free
);

  // Reset loads the initial heap block; the head cell is the one that counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      off  <= '0;
      size <= W'(INIT_SIZE);
      free <= 1'b1;
    end else if (shift) begin
      off  <= in_off;
      size <= in_size;
      free <= in_free;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ffha_queue.sv
// Small in-order queue between the edit stage and the tail of the cell chain.
// Takes up to two entries per cycle and releases one per cycle while read and not empty.
// Depends on ffha_pkg.
`default_nettype none

module ffha_queue
  import ffha_pkg::*;
#(
  parameter int W     = 53,
  parameter int DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr0,
  input  wire logic [W-1:0] wdata0,
  input  wire logic         wr1,
  input  wire logic [W-1:0] wdata1,
  input  wire logic         rd,
  output logic      [W-1:0] rdata,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   fill;
  logic [PW-1:0] wp1;
  logic          do_rd;

  assign empty = (fill == '0);
  assign rdata = mem[rp];
  assign do_rd = rd && !empty;
  assign wp1   = wr0 ? wp + PW'(1) : wp;

  // Storage: the second write lands after the first one.
  always_ff @(posedge clk) begin
    if (wr0) begin
      mem[wp] <= wdata0;
    end
    if (wr1) begin
      mem[wp1] <= wdata1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      wp   <= wp + PW'(wr0) + PW'(wr1);
      rp   <= rp + PW'(do_rd);
      fill <= fill + (PW+1)'(wr0) + (PW+1)'(wr1) - (PW+1)'(do_rd);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over an address-ordered chain of block cells.
// A zero size or null request answers straight from the idle state; any other
// request goes through the setup, pass and finish states, the pass state lasting
// one full lap of the cell chain plus the drain of the edit queue. One request at a time.
// Reset restores one free block filling the first page and the full page budget.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS      = 256,
  parameter int PAGE_BYTES      = 4096,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_SPLIT_BYTES = 16,
  parameter int MAX_HEAP_PAGES  = 12288
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              request,
  output logic                   done,
  output rsp_t                   result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int PG_W    = $clog2(MAX_HEAP_PAGES + 1);
  localparam int HB_W    = $clog2(64'(MAX_HEAP_PAGES) * 64'(PAGE_BYTES) + 64'd1);
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int EW      = (HB_W > 34 ? HB_W : 34) + 1;
  localparam int LIM_W   = (PG_W > BUDGET_W ? PG_W : BUDGET_W) + 1;
  localparam int DRAIN   = 6;
  localparam int CYC_W   = $clog2(MAX_BLOCKS + DRAIN + 1);
  localparam int ENT_W   = 2 * HB_W + 1;
  localparam int QDEPTH  = 16;

  typedef struct packed {
    logic [HB_W-1:0] off;
    logic [HB_W-1:0] size;
    logic            free;
  } ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_PASS,
    S_FINISH
  } state_t;

  state_t state;

  // Architectural state.
  logic [BUDGET_W-1:0] budget;
  logic [CNT_W-1:0]    count;
  logic [PG_W-1:0]     pages;
  logic [HB_W-1:0]     used_tot;
  logic [HB_W-1:0]     free_tot;

  // Request context.
  logic            op_free;
  logic [EW-1:0]   s_len;
  logic [31:0]     addr_q;
  logic [CNT_W-1:0] n_scan;
  logic            grow_ok;
  logic [PG_W-1:0] grow_pages;
  logic [CYC_W-1:0] cyc;

  // Edit stage registers.
  ent_t        hd;
  logic        hv;
  logic        absorb;
  logic        found;
  logic        appended;
  logic        free_ok;
  logic [31:0] aaddr;

  // Next values of the edit stage.
  ent_t            hd_next;
  logic            hv_next;
  logic            absorb_next;
  logic            found_next;
  logic            appended_next;
  logic            free_ok_next;
  logic [31:0]     aaddr_next;
  logic [CNT_W-1:0] count_next;
  logic [HB_W-1:0] used_next;
  logic [HB_W-1:0] free_next;
  logic            en0;
  logic            en1;
  ent_t            e1;

  // Cell chain wiring.
  logic [HB_W-1:0] c_off  [MAX_BLOCKS];
  logic [HB_W-1:0] c_size [MAX_BLOCKS];
  logic            c_free [MAX_BLOCKS];
  logic [ENT_W-1:0] q_rdata;
  ent_t            q_head;
  logic            q_empty;
  logic            q_rd;
  logic            shift;
  ent_t            x;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BUDGET) ? APB_DW'(budget) : '0;
  assign shift  = (state == S_PASS);
  assign q_rd   = (state == S_PASS) && (cyc >= CYC_W'(DRAIN)) && !q_empty;
  assign q_head = ent_t'(q_rdata);
  assign x      = '{off: c_off[0], size: c_size[0], free: c_free[0]};

  // The chain of cells; the tail is fed from the edit queue.
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [HB_W-1:0] n_off;
    logic [HB_W-1:0] n_size;
    logic            n_free;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign n_off  = q_head.off;
      assign n_size = q_head.size;
      assign n_free = q_head.free;
    end else begin : g_mid
      assign n_off  = c_off[k+1];
      assign n_size = c_size[k+1];
      assign n_free = c_free[k+1];
    end
    ffha_cell #(
      .W         (HB_W),
      .INIT_SIZE (PAGE_BYTES - HEADER_BYTES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .in_off  (n_off),
      .in_size (n_size),
      .in_free (n_free),
      .off     (c_off[k]),
      .size    (c_size[k]),
      .free    (c_free[k])
    );
  end

  ffha_queue #(
    .W     (ENT_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr0    (en0 && (state == S_PASS)),
    .wdata0 (ENT_W'(hd)),
    .wr1    (en1 && (state == S_PASS)),
    .wdata1 (ENT_W'(e1)),
    .rd     (q_rd),
    .rdata  (q_rdata),
    .empty  (q_empty)
  );

  // Page growth figures, worked out once per request.
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] avail;
  logic [EW-1:0]    need;
  logic             fits;
  logic [EW-1:0]    s_round;

  always_comb begin
    limit = (LIM_W'(budget) < LIM_W'(MAX_HEAP_PAGES)) ? LIM_W'(budget)
                                                      : LIM_W'(MAX_HEAP_PAGES);
    avail = (limit > LIM_W'(pages)) ? limit - LIM_W'(pages) : '0;
    need  = (s_len + EW'(HEADER_BYTES) + EW'(PAGE_BYTES - 1)) >> PAGE_SH;
    fits  = need <= EW'(avail);
    s_round = (EW'(request.req_size) + EW'(3)) & ~EW'(3);
  end

  // Position of the popped entry against the table length.
  logic inrange;
  logic at_end;
  assign inrange = CYC_W'(n_scan) > cyc;
  assign at_end  = CYC_W'(n_scan) == cyc;

  // Candidate for allocation: the popped entry, or a block appended at the end.
  ent_t            nblk;
  ent_t            cand;
  ent_t            a_ent;
  ent_t            b_ent;
  logic [HB_W-1:0] grow_end;
  logic            fit_here;
  logic            split;
  logic            room;
  logic            match;

  always_comb begin
    grow_end  = HB_W'(grow_pages) << PAGE_SH;
    nblk.off  = hd.off + HB_W'(HEADER_BYTES) + hd.size;
    nblk.size = grow_end - nblk.off - HB_W'(HEADER_BYTES);
    nblk.free = 1'b1;
    cand      = at_end ? nblk : x;
    if (inrange) begin
      fit_here = !found && x.free && (EW'(x.size) >= s_len);
      room     = (CNT_W+1)'(n_scan) < (CNT_W+1)'(MAX_BLOCKS);
    end else begin
      fit_here = at_end && !found && grow_ok &&
                 ((CNT_W+1)'(n_scan) < (CNT_W+1)'(MAX_BLOCKS));
      room     = ((CNT_W+1)'(n_scan) + (CNT_W+1)'(1)) < (CNT_W+1)'(MAX_BLOCKS);
    end
    split      = room && (EW'(cand.size) >=
                          s_len + EW'(HEADER_BYTES) + EW'(MIN_SPLIT_BYTES));
    a_ent.off  = cand.off;
    a_ent.size = split ? HB_W'(s_len) : cand.size;
    a_ent.free = 1'b0;
    b_ent.off  = cand.off + HB_W'(HEADER_BYTES) + HB_W'(s_len);
    b_ent.size = HB_W'(EW'(cand.size) - s_len - EW'(HEADER_BYTES));
    b_ent.free = 1'b1;
    match      = (34'(HEAP_BASE) + 34'(x.off) + 34'(HEADER_BYTES)) == 34'(addr_q);
  end

  // Edit stage: rewrites the entry stream for one lap of the chain.
  always_comb begin
    hd_next       = hd;
    hv_next       = hv;
    absorb_next   = absorb;
    found_next    = found;
    appended_next = appended;
    free_ok_next  = free_ok;
    aaddr_next    = aaddr;
    count_next    = count;
    used_next     = used_tot;
    free_next     = free_tot;
    en0           = 1'b0;
    en1           = 1'b0;
    e1            = a_ent;
    if (!op_free) begin
      if (fit_here) begin
        found_next    = 1'b1;
        appended_next = at_end;
        en0           = hv;
        hv_next       = 1'b1;
        if (split) begin
          en1     = 1'b1;
          hd_next = b_ent;
        end else begin
          hd_next = a_ent;
        end
        used_next  = used_tot + a_ent.size;
        free_next  = free_tot - (at_end ? '0 : cand.size) + (split ? b_ent.size : '0);
        count_next = count + CNT_W'(at_end) + CNT_W'(split);
        aaddr_next = 32'(34'(HEAP_BASE) + 34'(cand.off) + 34'(HEADER_BYTES));
      end else if (inrange) begin
        en0     = hv;
        hd_next = x;
        hv_next = 1'b1;
      end else begin
        en0     = hv;
        hv_next = 1'b0;
      end
    end else begin
      if (inrange) begin
        if (absorb) begin
          // The freed block takes in a free right-hand neighbor.
          absorb_next = 1'b0;
          if (x.free) begin
            hd_next.size = hd.size + HB_W'(HEADER_BYTES) + x.size;
            free_next    = free_tot + HB_W'(HEADER_BYTES);
            count_next   = count - CNT_W'(1);
          end else begin
            en0     = hv;
            hd_next = x;
            hv_next = 1'b1;
          end
        end else if (!found && match) begin
          found_next = 1'b1;
          if (x.free) begin
            // Double free leaves the table as it is.
            en0     = hv;
            hd_next = x;
            hv_next = 1'b1;
          end else begin
            free_ok_next = 1'b1;
            absorb_next  = 1'b1;
            used_next    = used_tot - x.size;
            if (hv && hd.free) begin
              hd_next.size = hd.size + HB_W'(HEADER_BYTES) + x.size;
              free_next    = free_tot + x.size + HB_W'(HEADER_BYTES);
              count_next   = count - CNT_W'(1);
            end else begin
              en0          = hv;
              hd_next      = x;
              hd_next.free = 1'b1;
              hv_next      = 1'b1;
              free_next    = free_tot + x.size;
            end
          end
        end else begin
          en0     = hv;
          hd_next = x;
          hv_next = 1'b1;
        end
      end else begin
        en0         = hv;
        hv_next     = 1'b0;
        absorb_next = 1'b0;
      end
    end
  end

  // Outcome of the request once the lap is complete.
  status_t         fin_status;
  logic [PG_W-1:0] fin_pages;

  always_comb begin
    fin_pages = pages;
    if (op_free) begin
      fin_status = free_ok ? ST_OK : ST_BAD_PTR;
    end else if (found) begin
      fin_status = ST_OK;
      if (appended) begin
        fin_pages = grow_pages;
      end
    end else if ((CNT_W+1)'(n_scan) >= (CNT_W+1)'(MAX_BLOCKS)) begin
      fin_status = ST_TABLE_FULL;
    end else begin
      fin_status = ST_NO_MEMORY;
      fin_pages  = grow_pages;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (psel && penable && pwrite && pready) begin
      budget <= BUDGET_W'(pwdata);
    end
  end

  // Sequencer, allocator state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      count    <= CNT_W'(1);
      pages    <= PG_W'(1);
      used_tot <= '0;
      free_tot <= HB_W'(PAGE_BYTES - HEADER_BYTES);
      cyc      <= '0;
      hv       <= 1'b0;
      absorb   <= 1'b0;
      found    <= 1'b0;
      appended <= 1'b0;
      free_ok  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_free <= (request.func == FUNC_FREE);
            s_len   <= s_round;
            addr_q  <= request.address;
            if ((request.func == FUNC_ALLOC && request.req_size == '0) ||
                (request.func == FUNC_FREE && request.address == '0)) begin
              done                 <= 1'b1;
              result.status        <= ST_ZERO_NULL;
              result.alloc_address <= '0;
              result.held_bytes    <= 26'(used_tot);
              result.spare_bytes   <= 26'(free_tot);
              result.block_count   <= 9'(count);
              result.heap_pages    <= 14'(pages);
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          grow_ok    <= fits;
          grow_pages <= pages + (fits ? PG_W'(need) : PG_W'(avail));
          n_scan     <= count;
          cyc        <= '0;
          hv         <= 1'b0;
          absorb     <= 1'b0;
          found      <= 1'b0;
          appended   <= 1'b0;
          free_ok    <= 1'b0;
          aaddr      <= '0;
          state      <= S_PASS;
        end
        S_PASS: begin
          hd       <= hd_next;
          hv       <= hv_next;
          absorb   <= absorb_next;
          found    <= found_next;
          appended <= appended_next;
          free_ok  <= free_ok_next;
          aaddr    <= aaddr_next;
          count    <= count_next;
          used_tot <= used_next;
          free_tot <= free_next;
          cyc      <= cyc + CYC_W'(1);
          if (cyc == CYC_W'(MAX_BLOCKS + DRAIN - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          pages                <= fin_pages;
          done                 <= 1'b1;
          result.status        <= fin_status;
          result.alloc_address <= (!op_free && found) ? aaddr : '0;
          result.held_bytes    <= 26'(used_tot);
          result.spare_bytes   <= 26'(free_tot);
          result.block_count   <= 9'(count);
          result.heap_pages    <= 14'(fin_pages);
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### test/first_fit_heap_allocator_unit_tb.sv
// Testbench for the first-fit heap allocator: directed and random requests
// checked against an in-bench model of the block table. Depends on ffha_pkg
// and first_fit_heap_allocator_unit.
module first_fit_heap_allocator_unit_tb
  import ffha_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 256;
  localparam longint unsigned PAGE = 4096;
  localparam longint unsigned HDR = 16;
  localparam longint unsigned SPLIT = 16;
  localparam longint unsigned MAXP = 12288;
  localparam int DRAIN_CYCLES = NBLK + 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  first_fit_heap_allocator_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Model of the block table and totals.
  longint unsigned blk_off[NBLK];
  longint unsigned blk_size[NBLK];
  bit blk_free[NBLK];
  int unsigned blk_count;
  longint unsigned pages_mapped;
  longint unsigned bytes_used;
  longint unsigned bytes_free;
  longint unsigned budget;

  rsp_t pending_results[$];
  logic [31:0] live_ptrs[$];
  logic [31:0] freed_ptrs[$];
  int errors = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("first_fit_heap_allocator_unit_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Open a table slot at index k, moving later entries up by one.
  function automatic void open_entry(int k);
    int j;
    for (j = blk_count; j > k; j--) begin
      blk_off[j] = blk_off[j-1];
      blk_size[j] = blk_size[j-1];
      blk_free[j] = blk_free[j-1];
    end
    blk_count++;
  endfunction

  // Remove the table slot at index k.
  function automatic void close_entry(int k);
    int j;
    for (j = k; j < blk_count - 1; j++) begin
      blk_off[j] = blk_off[j+1];
      blk_size[j] = blk_size[j+1];
      blk_free[j] = blk_free[j+1];
    end
    blk_count--;
  endfunction

  function automatic status_t alloc_block(longint unsigned req,
                                          output longint unsigned addr);
    longint unsigned s, lim, avail, need, nb, whole;
    int i, n;
    addr = 0;
    s = (req + 3) & ~64'd3;
    n = blk_count;
    for (i = 0; i < n; i++) begin
      if (blk_free[i] && blk_size[i] >= s) break;
    end
    // Nothing fits: grow the heap at its end, unless the table is full or the budget falls short.
    if (i == n) begin
      lim = (budget < MAXP) ? budget : MAXP;
      avail = (lim > pages_mapped) ? lim - pages_mapped : 0;
      need = (s + HDR + PAGE - 1) / PAGE;
      if (n >= NBLK) return ST_TABLE_FULL;
      if (need > avail) begin
        pages_mapped += avail;
        return ST_NO_MEMORY;
      end
      pages_mapped += need;
      nb = blk_off[n-1] + HDR + blk_size[n-1];
      blk_off[n] = nb;
      blk_size[n] = pages_mapped * PAGE - nb - HDR;
      blk_free[n] = 1'b1;
      blk_count++;
      bytes_free += blk_size[n];
    end
    // Take the block, splitting off the rest when it is large enough and the table has room.
    whole = blk_size[i];
    bytes_free -= whole;
    if (whole >= s + HDR + SPLIT && blk_count < NBLK) begin
      open_entry(i + 1);
      blk_off[i+1] = blk_off[i] + HDR + s;
      blk_size[i+1] = whole - s - HDR;
      blk_free[i+1] = 1'b1;
      bytes_free += blk_size[i+1];
      blk_size[i] = s;
    end
    blk_free[i] = 1'b0;
    bytes_used += blk_size[i];
    addr = HEAP_BASE + blk_off[i] + HDR;
    return ST_OK;
  endfunction

  function automatic status_t release_block(longint unsigned addr);
    int i, n;
    n = blk_count;
    for (i = 0; i < n; i++) begin
      if (HEAP_BASE + blk_off[i] + HDR == addr) break;
    end
    if (i == n || blk_free[i]) return ST_BAD_PTR;
    bytes_used -= blk_size[i];
    bytes_free += blk_size[i];
    blk_free[i] = 1'b1;
    // Merge with the next block, then with the previous one.
    if (i + 1 < blk_count && blk_free[i+1]) begin
      blk_size[i] += HDR + blk_size[i+1];
      bytes_free += HDR;
      close_entry(i + 1);
    end
    if (i > 0 && blk_free[i-1]) begin
      blk_size[i-1] += HDR + blk_size[i];
      bytes_free += HDR;
      close_entry(i);
    end
    return ST_OK;
  endfunction

  // Apply one accepted request to the model and queue its expected result.
  function automatic void predict_request(req_t r);
    rsp_t exp_rsp;
    longint unsigned aaddr;
    status_t st;
    int k;
    aaddr = 0;
    if (r.func == FUNC_ALLOC) begin
      st = (r.req_size == 0) ? ST_ZERO_NULL : alloc_block(r.req_size, aaddr);
      if (st == ST_OK) live_ptrs.push_back(aaddr[31:0]);
    end else begin
      st = (r.address == 0) ? ST_ZERO_NULL : release_block(r.address);
      if (st == ST_OK) begin
        for (k = 0; k < live_ptrs.size(); k++) begin
          if (live_ptrs[k] == r.address) begin
            live_ptrs.delete(k);
            break;
          end
        end
        freed_ptrs.push_back(r.address);
        if (freed_ptrs.size() > 32) void'(freed_ptrs.pop_front());
      end
    end
    exp_rsp.status = st;
    exp_rsp.alloc_address = aaddr[31:0];
    exp_rsp.held_bytes = bytes_used[25:0];
    exp_rsp.spare_bytes = bytes_free[25:0];
    exp_rsp.block_count = blk_count[8:0];
    exp_rsp.heap_pages = pages_mapped[13:0];
    pending_results.push_back(exp_rsp);
  endfunction

  // Check every result strobe against the oldest expected result.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        e = pending_results.pop_front();
        if (result.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", result.status, e.status));
        if (result.alloc_address !== e.alloc_address)
          report_mismatch($sformatf("alloc_address %h, want %h",
                                    result.alloc_address, e.alloc_address));
        if (result.held_bytes !== e.held_bytes)
          report_mismatch($sformatf("held_bytes %0d, want %0d",
                                    result.held_bytes, e.held_bytes));
        if (result.spare_bytes !== e.spare_bytes)
          report_mismatch($sformatf("spare_bytes %0d, want %0d",
                                    result.spare_bytes, e.spare_bytes));
        if (result.block_count !== e.block_count)
          report_mismatch($sformatf("block_count %0d, want %0d",
                                    result.block_count, e.block_count));
        if (result.heap_pages !== e.heap_pages)
          report_mismatch($sformatf("heap_pages %0d, want %0d",
                                    result.heap_pages, e.heap_pages));
      end
    end
  end

  // Present one request and hold it until the block accepts it.
  task automatic send_request(input req_t r);
    @(negedge clk);
    start = 1'b1;
    request = r;
    do @(posedge clk); while (busy);
    predict_request(r);
  endtask

  // Idle the request side for a random number of cycles.
  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk);
      start = 1'b0;
      while ($urandom_range(99) < pct) @(negedge clk);
    end
  endtask

  task automatic send_alloc(input logic [31:0] size);
    req_t r;
    r.func = FUNC_ALLOC;
    r.req_size = size;
    r.address = $urandom;
    send_request(r);
  endtask

  task automatic send_free(input logic [31:0] addr);
    req_t r;
    r.func = FUNC_FREE;
    r.req_size = $urandom;
    r.address = addr;
    send_request(r);
  endtask

  // Wait until every expected result is in and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input int unsigned value);
    wait_idle();
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_BUDGET;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    budget = value & 32'h3FFF;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic free_all_live();
    while (live_ptrs.size() != 0) send_free(live_ptrs[0]);
  endtask

  // Zero size, null, bad pointer, double free and neighbor merging.
  task automatic test_special_cases();
    logic [31:0] a, b, c;
    send_alloc(32'd0);
    send_free(32'd0);
    send_alloc(32'd1);
    send_alloc(32'd5);
    send_alloc(32'd4080);
    send_free(32'hFFFF_FFFF);
    a = live_ptrs[0];
    b = live_ptrs[1];
    c = live_ptrs[2];
    send_free(a + 4);
    send_free(a);
    send_free(a);
    send_free(c);
    send_free(b);
    send_alloc(32'd4064);
    send_alloc(32'd4065);
    free_all_live();
  endtask

  // Page budget limits, shortfall and oversized requests.
  task automatic test_page_budget();
    write_budget(3);
    send_alloc(32'd8000);
    send_alloc(32'd8000);
    write_budget(6);
    send_alloc(32'd3 * 4096);
    send_alloc(32'hFFFF_FFFF);
    write_budget(1);
    send_alloc(32'h8000_0000);
    send_alloc(32'd100);
    free_all_live();
    write_budget(12288);
    send_alloc(32'h7FFF_FFFC);
    send_alloc(32'd20000);
    free_all_live();
  endtask

  // Fill the block table to hit the full table on split and on growth.
  task automatic test_table_full();
    int i;
    for (i = 0; i < 300; i++) send_alloc(i < 290 ? 32'd4 : 32'd5000);
    send_free(live_ptrs[3]);
    send_alloc(32'd1);
    free_all_live();
  endtask

  // Mostly well-formed alloc and free traffic with some noise mixed in.
  task automatic test_random_traffic(input int count, input int pct);
    int i, pick;
    logic [31:0] sz, p;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55 || live_ptrs.size() == 0) begin
        pick = $urandom_range(99);
        if (pick < 70) sz = $urandom_range(64, 1);
        else if (pick < 90) sz = $urandom_range(2000, 1);
        else if (pick < 99) sz = $urandom_range(20000, 4000);
        else sz = $urandom;
        send_alloc(sz);
      end else if (pick < 90) begin
        send_free(live_ptrs[$urandom_range(live_ptrs.size() - 1)]);
      end else begin
        pick = $urandom_range(4);
        case (pick)
          0: send_alloc(32'd0);
          1: send_free(32'd0);
          2: send_free($urandom);
          3: begin
            p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
            send_free(p + 4 * $urandom_range(3, 1));
          end
          default: begin
            if (freed_ptrs.size() != 0)
              send_free(freed_ptrs[$urandom_range(freed_ptrs.size() - 1)]);
            else
              send_free($urandom);
          end
        endcase
      end
      if (live_ptrs.size() > 200) free_all_live();
      sender_gap(pct);
    end
  endtask

  initial begin
    blk_off[0] = 0;
    blk_size[0] = PAGE - HDR;
    blk_free[0] = 1'b1;
    blk_count = 1;
    pages_mapped = 1;
    bytes_used = 0;
    bytes_free = PAGE - HDR;
    budget = 12288;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_cases();
    test_page_budget();
    test_table_full();
    test_random_traffic(130, 0);
    write_budget(200);
    test_random_traffic(120, 69);
    write_budget(12288);
    test_random_traffic(120, 18);
    wait_idle();

    if (errors == 0) begin
      $display("first_fit_heap_allocator_unit_tb: PASS");
    end else begin
      $display("first_fit_heap_allocator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_cell.sv
hw/rtl/ffha_queue.sv
hw/rtl/first_fit_heap_allocator_unit.sv
test/first_fit_heap_allocator_unit_tb.sv
